// ----- rtl/core/hrf_pkg.sv -----
// Shared types, constants and pattern tables of the HTTP request framer.
package hrf_pkg;

   // Widths of the framing counters.
   localparam int CountWidth   = 16;
   localparam int ContentWidth = 17;
   localparam int TotalWidth   = 18;

   // Pattern lengths, the saturation values of the content length and the byte count, and the capacity reset value.
   localparam logic [4:0] NameLen = 5'd17;
   localparam logic [2:0] TermLen = 3'd4;
   localparam logic [ContentWidth-1:0] ContentMax = 17'h1FFFF;
   localparam logic [CountWidth-1:0]   CountMax   = 16'hFFFF;
   localparam logic [CountWidth-1:0]   CapacityReset = 16'd4096;

   // Characters that matter to the scanners.
   localparam logic [7:0] CharCr    = 8'h0D;
   localparam logic [7:0] CharLf    = 8'h0A;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;

   // Register index of the capacity register.
   localparam logic [0:0] RegCapacity = 1'b0;

   // Result codes of one beat.
   typedef enum logic [1:0] {
      ST_PENDING  = 2'd0,
      ST_COMPLETE = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_IGNORED  = 2'd3
   } hrf_status_type;

   // Progress of the Content-Length value parser.
   typedef enum logic [1:0] {
      PH_SEEK   = 2'd0,
      PH_SPACE  = 2'd1,
      PH_DIGITS = 2'd2,
      PH_DONE   = 2'd3
   } hrf_phase_type;

   // One result beat.
   typedef struct packed {
      hrf_status_type          status;
      logic [CountWidth-1:0]   request_length;
      logic [CountWidth-1:0]   header_length;
   } hrf_result_type;

   // CR LF "Content-Length:" one character per index.
   function automatic logic [7:0] hrf_name_char(input logic [4:0] idx);
      logic [7:0] ch;
      unique case (idx)
         5'd0:    ch = CharCr;
         5'd1:    ch = CharLf;
         5'd2:    ch = 8'h43; // C
         5'd3:    ch = 8'h6F; // o
         5'd4:    ch = 8'h6E; // n
         5'd5:    ch = 8'h74; // t
         5'd6:    ch = 8'h65; // e
         5'd7:    ch = 8'h6E; // n
         5'd8:    ch = 8'h74; // t
         5'd9:    ch = 8'h2D; // -
         5'd10:   ch = 8'h4C; // L
         5'd11:   ch = 8'h65; // e
         5'd12:   ch = 8'h6E; // n
         5'd13:   ch = 8'h67; // g
         5'd14:   ch = 8'h74; // t
         5'd15:   ch = 8'h68; // h
         5'd16:   ch = 8'h3A; // :
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // CR LF CR LF one character per index.
   function automatic logic [7:0] hrf_term_char(input logic [1:0] idx);
      return idx[0] ? CharLf : CharCr;
   endfunction

endpackage

// ----- rtl/core/hrf_if.sv -----
// Valid/ready channel interfaces for request bytes and framing results.

// Request byte channel.
interface hrf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first;

   modport source (output valid, output data_byte, output first, input ready);
   modport sink   (input valid, input data_byte, input first, output ready);
endinterface

// Framing result channel.
interface hrf_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] request_length;
   logic [15:0] header_length;

   modport source (output valid, output status, output request_length,
                   output header_length, input ready);
   modport sink   (input valid, input status, input request_length,
                   input header_length, output ready);
endinterface

// ----- rtl/core/hrf_engine.sv -----
// Per-byte framing state and the combinational update that produces one result.
module hrf_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             data_byte,
   input  logic                   first,
   input  logic [15:0]            capacity,
   output hrf_pkg::hrf_result_type result
);
   import hrf_pkg::*;

   // Framing state.
   logic [CountWidth-1:0]   byte_count_ff, byte_count_in;
   logic [2:0]              term_match_ff, term_match_in;
   logic [4:0]              name_match_ff, name_match_in;
   hrf_phase_type           phase_ff, phase_in;
   logic [ContentWidth-1:0] content_ff, content_in;
   logic [TotalWidth-1:0]   total_ff, total_in;
   logic [CountWidth-1:0]   header_len_ff, header_len_in;
   logic                    headers_seen_ff, headers_seen_in;
   logic                    finished_ff, finished_in;

   // Outcome flags handed from the update to the result logic.
   logic          was_finished;
   hrf_status_type status_sel;

   // Next-state logic: clear on first, then scan this beat.
   always_comb begin
      logic                    at_start;
      logic                    just_found;
      logic                    is_digit;
      logic [3:0]              digit;
      logic [4:0]              nm;
      logic [2:0]              tm;
      logic [20:0]             scaled;
      logic [TotalWidth-1:0]   sum;
      logic [CountWidth:0]     next_fill;

      byte_count_in   = byte_count_ff;
      term_match_in   = term_match_ff;
      name_match_in   = name_match_ff;
      phase_in        = phase_ff;
      content_in      = content_ff;
      total_in        = total_ff;
      header_len_in   = header_len_ff;
      headers_seen_in = headers_seen_ff;
      finished_in     = finished_ff;
      status_sel      = ST_PENDING;
      just_found      = 1'b0;
      nm              = '0;
      tm              = '0;

      if (first) begin
         byte_count_in   = '0;
         term_match_in   = '0;
         name_match_in   = '0;
         phase_in        = PH_SEEK;
         content_in      = '0;
         total_in        = '0;
         header_len_in   = '0;
         headers_seen_in = 1'b0;
         finished_in     = 1'b0;
      end

      was_finished = finished_in;
      at_start     = (byte_count_in == '0);
      is_digit     = (data_byte >= CharZero) && (data_byte <= CharNine);
      digit        = 4'(data_byte - CharZero);
      scaled       = {1'b0, content_in, 3'b000} + {3'b000, content_in, 1'b0}
                     + {17'd0, digit};
      sum          = '0;
      next_fill    = '0;

      if (!was_finished) begin
         if (byte_count_in != CountMax) begin
            byte_count_in = byte_count_in + 1'b1;
         end

         if (!headers_seen_in) begin
            // Content-Length name search and value parse.
            unique case (phase_in)
               PH_SEEK: begin
                  nm = at_start ? 5'd2 : name_match_in;
                  if ((nm < NameLen) && (data_byte == hrf_name_char(nm))) begin
                     nm = nm + 1'b1;
                  end else begin
                     nm = (data_byte == CharCr) ? 5'd1 : 5'd0;
                  end
                  name_match_in = nm;
                  if (nm >= NameLen) begin
                     phase_in = PH_SPACE;
                  end
               end
               PH_SPACE: begin
                  if (is_digit) begin
                     content_in = {13'd0, digit};
                     phase_in   = PH_DIGITS;
                  end else if (data_byte != CharSpace) begin
                     phase_in = PH_DONE;
                  end
               end
               PH_DIGITS: begin
                  if (is_digit) begin
                     content_in = (scaled > {4'd0, ContentMax}) ? ContentMax
                                                                : scaled[16:0];
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               default: begin
               end
            endcase

            // Blank line search.
            tm = term_match_in;
            if ((tm < TermLen) && (data_byte == hrf_term_char(tm[1:0]))) begin
               tm = tm + 1'b1;
            end else begin
               tm = (data_byte == CharCr) ? 3'd1 : 3'd0;
            end
            term_match_in = tm;

            // The value ends before the terminator's LF, so the old value holds.
            if (tm >= TermLen) begin
               headers_seen_in = 1'b1;
               just_found      = 1'b1;
               sum             = {2'b00, byte_count_in} + {1'b0, content_ff};
               total_in        = sum;
               header_len_in   = byte_count_in;
            end
         end

         next_fill = {1'b0, byte_count_in} + 1'b1;
         if (just_found && (total_in >= {2'b00, capacity})) begin
            status_sel  = ST_OVERFLOW;
            finished_in = 1'b1;
         end else if (headers_seen_in && ({2'b00, byte_count_in} >= total_in)) begin
            status_sel  = ST_COMPLETE;
            finished_in = 1'b1;
         end else if (next_fill >= {1'b0, capacity}) begin
            status_sel  = ST_OVERFLOW;
            finished_in = 1'b1;
         end
      end
   end

   // Result fields of this beat.
   always_comb begin
      result.status         = was_finished ? ST_IGNORED : status_sel;
      result.request_length = (!was_finished && (status_sel == ST_COMPLETE))
                              ? total_in[CountWidth-1:0] : '0;
      result.header_length  = headers_seen_in ? header_len_in : '0;
   end

   // State registers advance once per processed beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff   <= '0;
         term_match_ff   <= '0;
         name_match_ff   <= '0;
         phase_ff        <= PH_SEEK;
         content_ff      <= '0;
         total_ff        <= '0;
         header_len_ff   <= '0;
         headers_seen_ff <= 1'b0;
         finished_ff     <= 1'b0;
      end else if (step) begin
         byte_count_ff   <= byte_count_in;
         term_match_ff   <= term_match_in;
         name_match_ff   <= name_match_in;
         phase_ff        <= phase_in;
         content_ff      <= content_in;
         total_ff        <= total_in;
         header_len_ff   <= header_len_in;
         headers_seen_ff <= headers_seen_in;
         finished_ff     <= finished_in;
      end
   end

endmodule

// ----- rtl/core/http_request_framer_unit.sv -----
// Top level of the HTTP request framer: byte channel, result channel, CSR port.

// The framer takes one request byte per beat and answers every byte with one
// result beat: pending, complete with the expected request length, overflow
// against the buffer capacity, or ignored once the request has finished. It
// sustains one byte per clock cycle while the result channel is not stalled;
// an accepted byte is loaded into the input register, and its result beat
// into the result register once that register is free or draining. The
// framing state update for one byte, including the multiply by ten of the
// Content-Length value and the capacity compares, is combinational.
// A byte with first set starts a new request. The capacity register lies at
// address 0, resets to 4096 and should be written only while no beats are in
// flight.
module http_request_framer_unit (
   input  logic        clock,
   input  logic        reset,
   hrf_req_if.sink     req_in,
   hrf_rsp_if.source   rsp_out,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import hrf_pkg::*;

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_first_ff;

   // Result register.
   logic           out_valid_ff, out_valid_in;
   hrf_result_type out_result_ff;
   hrf_result_type step_result;

   // Capacity register.
   logic [CountWidth-1:0] capacity_ff;
   logic                  csr_write;

   logic advance;
   logic take_in;

   // The input stage moves on when the result register is free or draining.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_out.ready);
   assign req_in.ready = !in_valid_ff || advance;
   assign take_in      = req_in.valid && req_in.ready;
   assign in_valid_in  = take_in || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_out.ready);

   // Framing state and per-byte update.
   hrf_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .first     (in_first_ff),
      .capacity  (capacity_ff),
      .result    (step_result)
   );

   // Pipeline valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Pipeline payloads.
   always_ff @(posedge clock) begin
      if (take_in) begin
         in_byte_ff  <= req_in.data_byte;
         in_first_ff <= req_in.first;
      end
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

   // Result channel.
   assign rsp_out.valid          = out_valid_ff;
   assign rsp_out.status         = out_result_ff.status;
   assign rsp_out.request_length = out_result_ff.request_length;
   assign rsp_out.header_length  = out_result_ff.header_length;

   // CSR write in the access phase; the single register decodes every address.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CapacityReset;
      end else if (csr_write) begin
         capacity_ff <= csr_pwdata[CountWidth-1:0];
      end
   end

   // CSR read data.
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == 2'(4 * RegCapacity)) begin
         csr_prdata = {16'd0, capacity_ff};
      end
   end

endmodule

// ----- rtl/core/hrf_checker.sv -----
// Port-level assertions for the HTTP request framer and their bind.
module hrf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_request_length,
   input logic [15:0] rsp_header_length
);
   import hrf_pkg::*;

   // No result beat is offered right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_request_length) && $stable(rsp_header_length))
      else $error("stalled result changed");

   // Only a complete beat carries a request length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_COMPLETE) |-> (rsp_request_length == '0))
      else $error("request length outside a complete beat");

   // A complete request has seen its headers and covers them.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_COMPLETE) |->
         (rsp_header_length != '0) && (rsp_request_length >= rsp_header_length))
      else $error("complete beat with inconsistent lengths");

endmodule

bind http_request_framer_unit hrf_checker u_hrf_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_out.valid),
   .rsp_ready          (rsp_out.ready),
   .rsp_status         (rsp_out.status),
   .rsp_request_length (rsp_out.request_length),
   .rsp_header_length  (rsp_out.header_length)
);

// ----- sim/http_request_framer_unit_test.sv -----
// Self-checking testbench of the HTTP request framer: directed bytes, random requests.
`timescale 1ns / 1ps

module http_request_framer_unit_test;
   import hrf_pkg::*;

   localparam int GapMax      = 8;
   localparam int DrainCycles = 6;
   localparam int NumPhases   = 9;
   localparam int ScriptRows  = 7;

   // One directed row: a text segment, or a lone byte where the text is empty.
   // A typed answer applies to the last byte of the row.
   typedef struct packed {
      logic           start_flag;
      logic [7:0]     lone_byte;
      logic           typed;
      hrf_result_type answer;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [1:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   hrf_req_if req_if ();
   hrf_rsp_if rsp_if ();

   http_request_framer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_in      (req_if),
      .rsp_out     (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Framing state as the block should hold it.
   logic [15:0]   fr_capacity;
   logic [15:0]   fr_count;
   logic [2:0]    fr_term;
   logic [4:0]    fr_name;
   hrf_phase_type fr_phase;
   logic [16:0]   fr_clen;
   logic [17:0]   fr_total;
   logic          fr_headers;
   logic          fr_done;

   string name_text = "\r\nContent-Length:";
   string term_text = "\r\n\r\n";

   hrf_result_type frame_answers [$];
   logic [7:0]     req_bytes [$];
   int             error_count = 0;
   int             counted = 0;
   bit             calm = 1'b0;

   // Directed part: stray bytes after reset, a request with the length header at
   // byte 0 that completes, then a byte after the finish.
   script_row_type script_rows [ScriptRows] = '{
      '{1'b0, 8'h00, 1'b1, '{ST_PENDING,  16'd0,  16'd0}},
      '{1'b0, 8'hFF, 1'b1, '{ST_PENDING,  16'd0,  16'd0}},
      '{1'b1, 8'h00, 1'b1, '{ST_PENDING,  16'd0,  16'd0}},
      '{1'b0, 8'h00, 1'b1, '{ST_PENDING,  16'd0,  16'd21}},
      '{1'b0, 8'h00, 1'b1, '{ST_PENDING,  16'd0,  16'd21}},
      '{1'b0, 8'h00, 1'b1, '{ST_COMPLETE, 16'd23, 16'd21}},
      '{1'b0, 8'hFF, 1'b1, '{ST_IGNORED,  16'd0,  16'd21}}
   };
   string script_text [ScriptRows] = '{
      "", "", "Content-Length: 2", "\r\n\r\n", "A", "B", ""
   };

   function automatic void clear_frame();
      fr_count   = '0;
      fr_term    = '0;
      fr_name    = '0;
      fr_phase   = PH_SEEK;
      fr_clen    = '0;
      fr_total   = '0;
      fr_headers = 1'b0;
      fr_done    = 1'b0;
   endfunction

   // Advances a pattern match by one byte; a CR that does not continue the match restarts it.
   function automatic int step_match(int m, int len, string pat, logic [7:0] b);
      if (m < len && b == pat[m]) begin
         return m + 1;
      end
      return (b == CharCr) ? 1 : 0;
   endfunction

   // Updates the framing state with one byte and returns the result beat it causes.
   function automatic hrf_result_type frame_byte(logic [7:0] b, logic start_flag);
      hrf_result_type ans;
      logic at_start;
      logic just_found;
      logic digit;
      int   m;
      int   v;
      if (start_flag) begin
         clear_frame();
      end
      ans.status = ST_PENDING;
      ans.request_length = '0;
      if (fr_done) begin
         ans.status = ST_IGNORED;
      end else begin
         at_start = (fr_count == 0);
         just_found = 1'b0;
         digit = (b >= CharZero) && (b <= CharNine);
         if (fr_count != CountMax) begin
            fr_count = fr_count + 16'd1;
         end
         if (!fr_headers) begin
            // The Content-Length scan: name, then spaces, then digits.
            case (fr_phase)
               PH_SEEK: begin
                  m = step_match(at_start ? 2 : int'(fr_name), int'(NameLen), name_text, b);
                  fr_name = 5'(m);
                  if (m >= int'(NameLen)) begin
                     fr_phase = PH_SPACE;
                  end
               end
               PH_SPACE: begin
                  if (digit) begin
                     fr_clen = 17'(b - CharZero);
                     fr_phase = PH_DIGITS;
                  end else if (b != CharSpace) begin
                     fr_phase = PH_DONE;
                  end
               end
               PH_DIGITS: begin
                  if (digit) begin
                     v = int'(fr_clen) * 10 + int'(b - CharZero);
                     fr_clen = (v > int'(ContentMax)) ? ContentMax : 17'(v);
                  end else begin
                     fr_phase = PH_DONE;
                  end
               end
               default: ;
            endcase
            // The blank line that ends the headers.
            fr_term = 3'(step_match(int'(fr_term), int'(TermLen), term_text, b));
            if (fr_term >= TermLen) begin
               fr_headers = 1'b1;
               just_found = 1'b1;
               fr_total = 18'(fr_count) + 18'(fr_clen);
            end
         end
         if (just_found && int'(fr_total) + 1 > int'(fr_capacity)) begin
            ans.status = ST_OVERFLOW;
            fr_done = 1'b1;
         end else if (fr_headers && 18'(fr_count) >= fr_total) begin
            ans.status = ST_COMPLETE;
            ans.request_length = fr_total[15:0];
            fr_done = 1'b1;
         end else if (int'(fr_count) + 1 >= int'(fr_capacity)) begin
            ans.status = ST_OVERFLOW;
            fr_done = 1'b1;
         end
      end
      ans.header_length = fr_headers ? 16'(fr_total - 18'(fr_clen)) : '0;
      return ans;
   endfunction

   // Sends one request byte, after a random gap unless calm, and queues the answer it must get.
   task automatic send_byte(logic [7:0] b, logic start_flag, logic typed,
                            hrf_result_type typed_answer);
      int gap;
      hrf_result_type predicted;
      gap = calm ? 0 : $urandom_range(0, GapMax);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data_byte <= b;
      req_if.first <= start_flag;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predicted = frame_byte(b, start_flag);
      frame_answers.push_back(typed ? typed_answer : predicted);
      counted++;
   endtask

   // Stops sending and waits until every result beat has come back.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (frame_answers.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Writes the capacity register, then reads it back.
   task automatic write_capacity(logic [15:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 2'(4 * RegCapacity);
      csr_pwdata <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      fr_capacity = value;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata[15:0] !== value) begin
         $display("%0t: capacity read back expected %0d, got %0d",
                  $time, value, csr_prdata[15:0]);
         error_count++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         req_bytes.push_back(s[i]);
      end
   endfunction

   function automatic void put_word(int n);
      for (int i = 0; i < n; i++) begin
         req_bytes.push_back(8'(8'h61 + $urandom_range(0, 25)));
      end
   endfunction

   function automatic void put_length_line(string digits, logic mistyped);
      put_text(mistyped ? "content-length:" : "Content-Length:");
      repeat ($urandom_range(0, 3)) req_bytes.push_back(CharSpace);
      put_text(digits);
      put_text("\r\n");
   endfunction

   // Builds one random request: mostly well formed with random content, some
   // with a broken length value, a damaged byte, a cut or plain noise.
   function automatic void build_request();
      int    value;
      int    variant;
      int    body;
      int    extra_headers;
      int    cl_slot;
      int    keep;
      logic  mistyped;
      string digits;
      req_bytes.delete();
      if ($urandom_range(0, 9) == 0) begin
         // Noise, biased toward the characters the scanners react to.
         repeat ($urandom_range(1, 24)) begin
            case ($urandom_range(0, 4))
               0:       req_bytes.push_back(CharCr);
               1:       req_bytes.push_back(CharLf);
               2:       req_bytes.push_back(8'(CharZero + $urandom_range(0, 9)));
               default: req_bytes.push_back(8'($urandom));
            endcase
         end
         return;
      end
      value = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 70000) : $urandom_range(0, 30);
      digits = $sformatf("%0d", value);
      variant = $urandom_range(0, 11);
      case (variant)
         0:       digits = "";
         1:       digits = {"+", digits};
         2:       digits = {"-", digits};
         3:       digits = {"\t", digits};
         4:       digits = {digits, "x7"};
         5:       digits = {digits, " 3"};
         6:       digits = "000123456789";
         default: ;
      endcase
      body = (variant <= 3) ? 0 : value;
      mistyped = ($urandom_range(0, 9) == 0);
      extra_headers = $urandom_range(0, 3);
      cl_slot = ($urandom_range(0, 7) == 0) ? -1 : $urandom_range(0, extra_headers);

      // The length header either opens the stream or sits among the headers.
      if ($urandom_range(0, 5) == 0) begin
         put_length_line(digits, mistyped);
         cl_slot = -1;
      end else begin
         put_text("GET /");
         put_word($urandom_range(0, 6));
         put_text(" HTTP/1.1\r\n");
      end
      for (int h = 0; h <= extra_headers; h++) begin
         if (h == cl_slot) begin
            put_length_line(digits, mistyped);
            if ($urandom_range(0, 5) == 0) begin
               put_text("Content-Length: 5\r\n");
            end
         end
         if (h < extra_headers) begin
            put_text("X-");
            put_word($urandom_range(1, 6));
            put_text(": ");
            put_word($urandom_range(0, 8));
            put_text("\r\n");
         end
      end
      put_text("\r\n");

      // Body: usually the announced size, sometimes short, sometimes with extra bytes.
      case ($urandom_range(0, 6))
         0:       body = $urandom_range(0, body);
         1:       body = body + $urandom_range(1, 6);
         default: ;
      endcase
      if (body > 600) begin
         body = 600;
      end
      repeat (body) req_bytes.push_back(8'($urandom));

      if ($urandom_range(0, 7) == 0) begin
         req_bytes[$urandom_range(0, req_bytes.size() - 1)] = 8'($urandom);
      end
      if ($urandom_range(0, 9) == 0) begin
         keep = $urandom_range(1, req_bytes.size());
         while (req_bytes.size() > keep) void'(req_bytes.pop_back());
      end
   endfunction

   // Switches both sides between stretches with idling and stretches without.
   initial begin : idle_mode
      forever begin
         calm = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(40, 300)) @(posedge clock);
      end
   end

   // Result side: random stalls, every beat compared with the oldest answer.
   initial begin : result_sink
      hrf_result_type want;
      int stall;
      rsp_if.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, GapMax);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         if (frame_answers.size() == 0) begin
            $display("%0t: result beat with nothing expected, status %0d",
                     $time, rsp_if.status);
            error_count++;
         end else begin
            want = frame_answers.pop_front();
            if (rsp_if.status !== want.status) begin
               $display("%0t: status expected %0d, got %0d",
                        $time, want.status, rsp_if.status);
               error_count++;
            end
            if (rsp_if.request_length !== want.request_length) begin
               $display("%0t: request_length expected %0d, got %0d",
                        $time, want.request_length, rsp_if.request_length);
               error_count++;
            end
            if (rsp_if.header_length !== want.header_length) begin
               $display("%0t: header_length expected %0d, got %0d",
                        $time, want.header_length, rsp_if.header_length);
               error_count++;
            end
         end
      end
   end

   // Stimulus: reset, the directed rows, then random phases at several capacities.
   initial begin : stimulus
      int   phase_caps [NumPhases];
      int   phase_budget [NumPhases];
      int   len;
      logic lead;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.data_byte <= '0;
      req_if.first <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      clear_frame();
      fr_capacity = CapacityReset;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < ScriptRows; r++) begin
         len = script_text[r].len();
         if (len == 0) begin
            send_byte(script_rows[r].lone_byte, script_rows[r].start_flag,
                      script_rows[r].typed, script_rows[r].answer);
         end else begin
            for (int i = 0; i < len; i++) begin
               send_byte(script_text[r][i], (i == 0) ? script_rows[r].start_flag : 1'b0,
                         script_rows[r].typed && (i == len - 1), script_rows[r].answer);
            end
         end
      end

      // Each phase sends a fixed number of bytes; a request may be cut at the end.
      phase_caps = '{0, 1, 2, 3, 65535, 4096, $urandom_range(16, 80),
                     $urandom_range(81, 400), $urandom_range(2, 65535)};
      phase_budget = '{20, 20, 30, 40, 400, 400, 400, 400, 120};
      for (int p = 0; p < NumPhases; p++) begin
         wait_idle();
         write_capacity(16'(phase_caps[p]));
         counted = 0;
         while (counted < phase_budget[p]) begin
            build_request();
            lead = ($urandom_range(0, 9) != 0);
            foreach (req_bytes[i]) begin
               if (counted >= phase_budget[p]) break;
               send_byte(req_bytes[i], (i == 0) ? lead : 1'b0, 1'b0, '0);
            end
         end
      end

      wait_idle();
      if (error_count == 0) begin
         $display("http_request_framer_unit_test: PASS");
      end else begin
         $display("http_request_framer_unit_test: FAIL");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin : watchdog
      #10_000_000;
      $display("http_request_framer_unit_test: FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/hrf_pkg.sv
rtl/core/hrf_if.sv
rtl/core/hrf_engine.sv
rtl/core/http_request_framer_unit.sv
rtl/core/hrf_checker.sv
sim/http_request_framer_unit_test.sv
